>>> sv/dss_pkg.sv
// Shared constants, register codes and queue status type for the diffusion stencil sweep.
package dss_pkg;

  localparam int DSS_MAX_WIDTH   = 1024;
  localparam int DSS_SAMPLE_BITS = 32;
  localparam int DSS_MAX_HEIGHT  = 4096;

  localparam int DSS_CFG_INDEX_BITS     = 2;
  localparam int DSS_CFG_DATA_BITS      = 17;
  localparam int DSS_CFG_WIDTH_BITS     = 11;
  localparam int DSS_HEIGHT_BITS        = 13;
  localparam int DSS_ROW_BITS           = 12;
  localparam int DSS_CENTER_GAIN_BITS   = 17;
  localparam int DSS_NEIGHBOR_GAIN_BITS = 15;

  localparam int DSS_GRID_MIN          = 3;
  localparam int DSS_CENTER_GAIN_MAX   = 65536;
  localparam int DSS_NEIGHBOR_GAIN_MAX = 16384;

  localparam int DSS_GRID_WIDTH_RESET    = 64;
  localparam int DSS_GRID_HEIGHT_RESET   = 64;
  localparam int DSS_CENTER_GAIN_RESET   = 65536;
  localparam int DSS_NEIGHBOR_GAIN_RESET = 0;

  // results are Q.16; products are Q.32
  localparam int DSS_FRAC_BITS = 16;
  localparam int DSS_ROUND     = 32768;

  localparam int DSS_QUEUE_DEPTH = 4;
  localparam int DSS_QPTR_BITS   = $clog2(DSS_QUEUE_DEPTH);
  localparam int DSS_QCNT_BITS   = $clog2(DSS_QUEUE_DEPTH + 1);

  typedef enum logic [DSS_CFG_INDEX_BITS-1:0] {
    DSS_REG_GRID_WIDTH    = 2'd0,
    DSS_REG_GRID_HEIGHT   = 2'd1,
    DSS_REG_CENTER_GAIN   = 2'd2,
    DSS_REG_NEIGHBOR_GAIN = 2'd3
  } dss_reg_t;

  typedef struct packed {
    logic                     nonempty;
    logic [DSS_QCNT_BITS-1:0] level;
  } dss_qstat_t;

endpackage

>>> sv/diffusion_stencil_sweep_unit.sv
// Top level of the Jacobi five-point diffusion sweep: configuration registers and the pipe.
//
// Samples of the old field enter on the in_ channel in raster order, one word per
// cycle while in_stall is low; in_frame_start marks cell (0,0). Each interior cell
// yields one word on the out_ channel holding center_gain*center + neighbor_gain*(four
// neighbors), rounded and saturated; out_last_of_frame flags the last interior cell.
// Boundary cells give nothing. The result for cell (c, r-1) is produced when sample
// (c, r) is accepted. A word passes the operand read from the two line buffers, the
// queue, the neighbor sum, the gain multiply and round/saturate. Throughput is one
// word per cycle while no stall holds, set by one write and two reads per cycle on
// the middle line buffer. A 4-entry queue splits the operand front end from the
// arithmetic back end; when the receiver raises out_stall the back end holds, the
// queue fills, and in_stall rises once the queue and the word in flight leave no room.
// Reset clears the raster position, the pipe and loads the default registers; the line
// buffers are not cleared and a frame must begin with in_frame_start. The user must write
// registers via cfg_wr_en/cfg_index/cfg_data only while idle; the block does not check.
module diffusion_stencil_sweep_unit #(
  parameter int MAX_WIDTH   = dss_pkg::DSS_MAX_WIDTH,
  parameter int SAMPLE_BITS = dss_pkg::DSS_SAMPLE_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [SAMPLE_BITS-1:0]            in_sample,
  input  logic                                     in_frame_start,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [SAMPLE_BITS-1:0]            out_new_value,
  output logic                                     out_last_of_frame,
  input  logic                                     cfg_wr_en,
  input  logic [dss_pkg::DSS_CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [dss_pkg::DSS_CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HB = dss_pkg::DSS_HEIGHT_BITS;
  localparam int GB = dss_pkg::DSS_CENTER_GAIN_BITS;
  localparam int NB = dss_pkg::DSS_NEIGHBOR_GAIN_BITS;
  localparam int QD = 5 * SAMPLE_BITS + 1;
  localparam int WIDTH_RESET = (dss_pkg::DSS_GRID_WIDTH_RESET > MAX_WIDTH) ?
                               MAX_WIDTH : dss_pkg::DSS_GRID_WIDTH_RESET;

  logic [WW-1:0] grid_width_r;
  logic [HB-1:0] grid_height_r;
  logic [GB-1:0] center_gain_r;
  logic [NB-1:0] neighbor_gain_r;

  logic [dss_pkg::DSS_CFG_WIDTH_BITS-1:0] width_in;
  logic [HB-1:0]                          height_in;
  logic [GB-1:0]                          cgain_in;
  logic [NB-1:0]                          ngain_in;
  logic [WW-1:0]                          width_cl;
  logic [HB-1:0]                          height_cl;
  logic [GB-1:0]                          cgain_cl;
  logic [NB-1:0]                          ngain_cl;

  logic                q_push, q_pop;
  logic [QD-1:0]       q_push_data, q_head_data;
  dss_pkg::dss_qstat_t q_stat;

  // out-of-range values are clamped on the way in
  always_comb begin
    width_in  = cfg_data[dss_pkg::DSS_CFG_WIDTH_BITS-1:0];
    height_in = cfg_data[HB-1:0];
    cgain_in  = cfg_data[GB-1:0];
    ngain_in  = cfg_data[NB-1:0];

    if (32'(width_in) < 32'(dss_pkg::DSS_GRID_MIN)) begin
      width_cl = WW'(dss_pkg::DSS_GRID_MIN);
    end else if (32'(width_in) > 32'(MAX_WIDTH)) begin
      width_cl = WW'(MAX_WIDTH);
    end else begin
      width_cl = WW'(width_in);
    end

    if (32'(height_in) < 32'(dss_pkg::DSS_GRID_MIN)) begin
      height_cl = HB'(dss_pkg::DSS_GRID_MIN);
    end else if (32'(height_in) > 32'(dss_pkg::DSS_MAX_HEIGHT)) begin
      height_cl = HB'(dss_pkg::DSS_MAX_HEIGHT);
    end else begin
      height_cl = height_in;
    end

    cgain_cl = (32'(cgain_in) > 32'(dss_pkg::DSS_CENTER_GAIN_MAX)) ?
               GB'(dss_pkg::DSS_CENTER_GAIN_MAX) : cgain_in;
    ngain_cl = (32'(ngain_in) > 32'(dss_pkg::DSS_NEIGHBOR_GAIN_MAX)) ?
               NB'(dss_pkg::DSS_NEIGHBOR_GAIN_MAX) : ngain_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r    <= WW'(WIDTH_RESET);
      grid_height_r   <= HB'(dss_pkg::DSS_GRID_HEIGHT_RESET);
      center_gain_r   <= GB'(dss_pkg::DSS_CENTER_GAIN_RESET);
      neighbor_gain_r <= NB'(dss_pkg::DSS_NEIGHBOR_GAIN_RESET);
    end else if (cfg_wr_en) begin
      case (dss_pkg::dss_reg_t'(cfg_index))
        dss_pkg::DSS_REG_GRID_WIDTH:    grid_width_r    <= width_cl;
        dss_pkg::DSS_REG_GRID_HEIGHT:   grid_height_r   <= height_cl;
        dss_pkg::DSS_REG_CENTER_GAIN:   center_gain_r   <= cgain_cl;
        dss_pkg::DSS_REG_NEIGHBOR_GAIN: neighbor_gain_r <= ngain_cl;
        default: begin
        end
      endcase
    end
  end

  dss_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .in_frame_start (in_frame_start),
    .grid_width     (grid_width_r),
    .grid_height    (grid_height_r),
    .q_stat         (q_stat),
    .push           (q_push),
    .push_data      (q_push_data)
  );

  dss_queue #(
    .DATA_BITS (QD)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head_data),
    .q_stat    (q_stat)
  );

  dss_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .center_gain       (center_gain_r),
    .neighbor_gain     (neighbor_gain_r),
    .q_stat            (q_stat),
    .head_data         (q_head_data),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_new_value     (out_new_value),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

>>> sv/dss_front.sv
// Front end: raster position tracking, line buffers and stencil operand gathering.
module dss_front #(
  parameter int MAX_WIDTH   = dss_pkg::DSS_MAX_WIDTH,
  parameter int SAMPLE_BITS = dss_pkg::DSS_SAMPLE_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [SAMPLE_BITS-1:0]            in_sample,
  input  logic                                     in_frame_start,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]           grid_width,
  input  logic [dss_pkg::DSS_HEIGHT_BITS-1:0]      grid_height,
  input  dss_pkg::dss_qstat_t                      q_stat,
  output logic                                     push,
  output logic [5*SAMPLE_BITS:0]                   push_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = WW + 1;
  localparam int HB = dss_pkg::DSS_HEIGHT_BITS;
  localparam int RB = dss_pkg::DSS_ROW_BITS;
  localparam int CB = dss_pkg::DSS_QCNT_BITS + 1;

  logic [SAMPLE_BITS-1:0] mid_row_mem   [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] above_row_mem [MAX_WIDTH];

  logic [AW-1:0] col_r, col_nxt;
  logic [RB-1:0] row_r, row_nxt;

  logic          accept;
  logic [AW-1:0] col_base, col_a, col_rd_next;
  logic [RB-1:0] row_base, row_a;
  logic [XW-1:0] w_x, w_m1, w_m2, colp1_x, colp2_x;
  logic [HB-1:0] h_m1, rowp1;
  logic          emit_a, last_a, wrap_a;

  // stage B: in the cycle after acceptance, memory read data has landed
  logic                   b_valid_r;
  logic                   b_emit_r;
  logic                   b_last_r;
  logic [AW-1:0]          b_col_r;
  logic [SAMPLE_BITS-1:0] b_down_r;
  logic [SAMPLE_BITS-1:0] center_rd_r;
  logic [SAMPLE_BITS-1:0] right_rd_r;
  logic [SAMPLE_BITS-1:0] up_rd_r;
  logic [SAMPLE_BITS-1:0] left_r;

  // room for the word in stage B plus the one accepted now
  assign in_stall = (CB'(q_stat.level) + CB'(b_valid_r)) >= CB'(dss_pkg::DSS_QUEUE_DEPTH);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    col_base = in_frame_start ? '0 : col_r;
    row_base = in_frame_start ? '0 : row_r;
    w_x      = XW'(grid_width);
    w_m1     = w_x - XW'(1);
    w_m2     = w_x - XW'(2);
    h_m1     = grid_height - HB'(1);

    // a position left over from a larger geometry is pulled back to the last cell
    col_a = (XW'(col_base) >= w_x) ? w_m1[AW-1:0] : col_base;
    row_a = (HB'(row_base) >= grid_height) ? h_m1[RB-1:0] : row_base;

    colp1_x     = XW'(col_a) + XW'(1);
    colp2_x     = XW'(col_a) + XW'(2);
    col_rd_next = (colp1_x < w_x) ? colp1_x[AW-1:0] : col_a;

    emit_a = (row_a >= RB'(2)) && (col_a != '0) && (colp2_x <= w_x);
    last_a = (HB'(row_a) == h_m1) && (XW'(col_a) == w_m2);

    wrap_a = colp1_x >= w_x;
    rowp1  = HB'(row_a) + HB'(1);
    if (wrap_a) begin
      col_nxt = '0;
      row_nxt = (rowp1 >= grid_height) ? '0 : rowp1[RB-1:0];
    end else begin
      col_nxt = colp1_x[AW-1:0];
      row_nxt = row_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      b_valid_r <= 1'b0;
      left_r    <= '0;
    end else begin
      b_valid_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (b_valid_r) begin
        left_r <= center_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_col_r  <= col_a;
      b_emit_r <= emit_a;
      b_last_r <= last_a;
      b_down_r <= in_sample;
    end
  end

  // middle row: read center and right neighbor, then overwrite with the new sample
  always_ff @(posedge clk) begin
    if (accept) begin
      mid_row_mem[col_a] <= in_sample;
      center_rd_r        <= mid_row_mem[col_a];
      right_rd_r         <= mid_row_mem[col_rd_next];
    end
  end

  // upper row is written from stage B; forward when that write hits the column read now
  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      above_row_mem[b_col_r] <= center_rd_r;
    end
    if (accept) begin
      if (b_valid_r && (b_col_r == col_a)) begin
        up_rd_r <= center_rd_r;
      end else begin
        up_rd_r <= above_row_mem[col_a];
      end
    end
  end

  assign push      = b_valid_r & b_emit_r;
  assign push_data = {b_last_r, center_rd_r, up_rd_r, b_down_r, left_r, right_rd_r};

  a_accept_reaches_b: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> b_valid_r)
    else $error("accepted word did not reach operand stage");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (q_stat.level != dss_pkg::DSS_QCNT_BITS'(dss_pkg::DSS_QUEUE_DEPTH)))
    else $error("push into a full queue");

endmodule

>>> sv/dss_queue.sv
// Short word queue between the operand front end and the arithmetic back end.
module dss_queue #(
  parameter int DATA_BITS = 5 * dss_pkg::DSS_SAMPLE_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] head_data,
  output dss_pkg::dss_qstat_t  q_stat
);

  localparam int PB    = dss_pkg::DSS_QPTR_BITS;
  localparam int NB    = dss_pkg::DSS_QCNT_BITS;
  localparam int DEPTH = dss_pkg::DSS_QUEUE_DEPTH;

  logic [DATA_BITS-1:0] entry_r [DEPTH];
  logic [PB-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PB-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [NB-1:0]        level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PB'(DEPTH - 1)) ? '0 : wr_ptr_r + PB'(1);
    rd_ptr_nxt = (rd_ptr_r == PB'(DEPTH - 1)) ? '0 : rd_ptr_r + PB'(1);
    level_nxt  = level_r + NB'(push) - NB'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      level_r <= level_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_data       = entry_r[rd_ptr_r];
  assign q_stat.nonempty = level_r != '0;
  assign q_stat.level    = level_r;

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (level_r != '0))
    else $error("pop from an empty queue");

endmodule

>>> sv/dss_back.sv
// Back end: neighbor sum, gain multiplies, rounding and saturation into the output register.
module dss_back #(
  parameter int SAMPLE_BITS = dss_pkg::DSS_SAMPLE_BITS
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic [dss_pkg::DSS_CENTER_GAIN_BITS-1:0]     center_gain,
  input  logic [dss_pkg::DSS_NEIGHBOR_GAIN_BITS-1:0]   neighbor_gain,
  input  dss_pkg::dss_qstat_t                          q_stat,
  input  logic [5*SAMPLE_BITS:0]                       head_data,
  output logic                                         pop,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic signed [SAMPLE_BITS-1:0]                out_new_value,
  output logic                                         out_last_of_frame
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = SB + 18;
  localparam int AW = SB + 19;
  localparam int QW = AW - dss_pkg::DSS_FRAC_BITS;

  logic          advance;
  logic [SB-1:0] h_ctr, h_up, h_down, h_left, h_right;
  logic          h_last;
  logic [SB+1:0] sum_nxt;

  logic          s1_valid_r, s1_last_r;
  logic [SB-1:0] s1_ctr_r;
  logic [SB+1:0] s1_sum_r;

  logic          s2_valid_r, s2_last_r;
  logic [PW-1:0] p0_nxt, p1_nxt, p0_r, p1_r;

  logic [AW-1:0] acc;
  logic [QW-1:0] q;
  logic [SB-1:0] sat;
  logic          fits;

  logic                 out_valid_r, out_last_r;
  logic signed [SB-1:0] out_value_r;

  // whole pipe moves together unless the output word is held
  assign advance = ~out_valid_r | ~out_stall;
  assign pop     = advance & q_stat.nonempty;

  assign h_right = head_data[SB-1:0];
  assign h_left  = head_data[2*SB-1:SB];
  assign h_down  = head_data[3*SB-1:2*SB];
  assign h_up    = head_data[4*SB-1:3*SB];
  assign h_ctr   = head_data[5*SB-1:4*SB];
  assign h_last  = head_data[5*SB];

  assign sum_nxt = {{2{h_up[SB-1]}}, h_up} + {{2{h_down[SB-1]}}, h_down}
                 + {{2{h_left[SB-1]}}, h_left} + {{2{h_right[SB-1]}}, h_right};

  // operands zero/sign extended to the product width; the exact product fits
  assign p0_nxt = {{18{s1_ctr_r[SB-1]}}, s1_ctr_r} * {{(SB + 1){1'b0}}, center_gain};
  assign p1_nxt = {{16{s1_sum_r[SB+1]}}, s1_sum_r} * {{(SB + 3){1'b0}}, neighbor_gain};

  always_comb begin
    acc  = {p0_r[PW-1], p0_r} + {p1_r[PW-1], p1_r} + AW'(dss_pkg::DSS_ROUND);
    q    = acc[AW-1:dss_pkg::DSS_FRAC_BITS];
    fits = (q[QW-1:SB-1] == '0) || (q[QW-1:SB-1] == '1);
    if (fits) begin
      sat = q[SB-1:0];
    end else if (q[QW-1]) begin
      sat = {1'b1, {(SB - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(SB - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= pop;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_ctr_r    <= h_ctr;
      s1_sum_r    <= sum_nxt;
      s1_last_r   <= h_last;
      p0_r        <= p0_nxt;
      p1_r        <= p1_nxt;
      s2_last_r   <= s1_last_r;
      out_value_r <= $signed(sat);
      out_last_r  <= s2_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_value     = out_value_r;
  assign out_last_of_frame = out_last_r;

  a_pop_lands: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> s1_valid_r)
    else $error("popped word lost before the sum stage");

endmodule
